// ===== src/drrip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared constants, codes and types of the DRRIP dead-block replacement engine.
// ----------------------------------------------------------------------------
package drrip_pkg;

  // Default geometry
  localparam int DEF_NUM_SETS      = 2048;
  localparam int DEF_NUM_WAYS      = 16;
  localparam int DEF_LEADER_SETS   = 64;
  localparam int DEF_SELECTOR_BITS = 10;

  // Port field widths
  localparam int SET_W      = 11;
  localparam int WAY_W      = 4;
  localparam int MASK_W     = 16;
  localparam int SELV_W     = 10;
  localparam int PERIOD_W   = 20;
  localparam int SEED_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  // Per-line state encoding
  localparam int LINE_W = 4;   // [1:0] re-reference value, [3:2] dead counter
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] DEAD_MAX     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED  = 1'd1;

  // Reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd100000;
  localparam logic [SEED_W-1:0]   SEED_RESET   = 16'd44257;

  // LFSR
  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
  localparam int BIMODAL_BITS = 5;   // 1-in-32 long insertion

  // Operation / reply codes
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic              op;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic              was_hit;
    logic [MASK_W-1:0] valid_mask;
    logic              set_ok;
    logic              way_ok;
    logic              leader;
    logic              srrip_leader;
  } item_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DECAY,
    BK_FETCH,
    BK_EXEC
  } back_state_t;

endpackage

// ===== src/drrip_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_front
// Accepts requests, range-checks set and way, tags leader sets, pushes queue.
// ----------------------------------------------------------------------------
module drrip_front #(
  parameter int NUM_SETS    = drrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS    = drrip_pkg::DEF_NUM_WAYS,
  parameter int LEADER_SETS = drrip_pkg::DEF_LEADER_SETS
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [drrip_pkg::SET_W-1:0] in_set_index,
  input  logic [drrip_pkg::WAY_W-1:0] in_way_index,
  input  logic                        in_was_hit,
  input  logic [drrip_pkg::MASK_W-1:0] in_valid_mask,
  input  logic                        q_full,
  input  logic                        clear_busy,
  output logic                        push,
  output drrip_pkg::item_t            push_item
);
  import drrip_pkg::*;

  localparam logic [31:0] SETS_LIM   = 32'(NUM_SETS);
  localparam logic [31:0] WAYS_LIM   = 32'(NUM_WAYS);
  localparam logic [31:0] SRRIP_LIM  = 32'(LEADER_SETS);
  localparam logic [31:0] LEADER_LIM = 32'(2 * LEADER_SETS);

  logic [31:0] set_ext;
  logic [31:0] way_ext;

  assign set_ext  = 32'(in_set_index);
  assign way_ext  = 32'(in_way_index);
  assign in_ready = !q_full && !clear_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.op           = in_operation;
    push_item.set_index    = in_set_index;
    push_item.way_index    = in_way_index;
    push_item.was_hit      = in_was_hit;
    push_item.valid_mask   = in_valid_mask;
    push_item.set_ok       = set_ext < SETS_LIM;
    push_item.way_ok       = way_ext < WAYS_LIM;
    push_item.srrip_leader = set_ext < SRRIP_LIM;
    push_item.leader       = set_ext < LEADER_LIM;
  end

endmodule

// ===== src/drrip_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_queue
// Two-entry request FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module drrip_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  drrip_pkg::item_t push_item,
  output logic             q_full,
  input  logic             pop,
  output logic             head_valid,
  output drrip_pkg::item_t head_item
);
  import drrip_pkg::*;

  item_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full     = cnt_r == QCNT_W'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/drrip_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_back
// Set-row memory, read-modify-write of one row per request, decay walk,
// reset clearing pass, policy selector, LFSR and result register.
// ----------------------------------------------------------------------------
module drrip_back #(
  parameter int NUM_SETS      = drrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS      = drrip_pkg::DEF_NUM_WAYS,
  parameter int SELECTOR_BITS = drrip_pkg::DEF_SELECTOR_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [drrip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drrip_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             head_valid,
  input  drrip_pkg::item_t                 head_item,
  output logic                             pop,
  output logic                             clear_busy,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_reply_kind,
  output logic [drrip_pkg::WAY_W-1:0]      out_victim_way,
  output logic [drrip_pkg::SELV_W-1:0]     out_selector_value
);
  import drrip_pkg::*;

  localparam int SW      = $clog2(NUM_SETS);
  localparam int WW      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROW_W   = NUM_WAYS * LINE_W;
  localparam int VIS_W   = (NUM_WAYS < MASK_W) ? NUM_WAYS : MASK_W;
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;
  localparam logic [SW-1:0] LAST_ROW = SW'(NUM_SETS - 1);
  localparam logic [SW:0]   WALK_END = (SW + 1)'(NUM_SETS);

  function automatic logic [ROW_W-1:0] init_row();
    logic [ROW_W-1:0] r;
    r = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r[w*LINE_W +: 2] = RRPV_DISTANT;
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] decay_row(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] o;
    logic [1:0]       d;
    o = r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      d = r[w*LINE_W+2 +: 2];
      if (d != 2'd0) begin
        o[w*LINE_W+2 +: 2] = d - 2'd1;
      end
    end
    return o;
  endfunction

  // Memory
  logic [ROW_W-1:0] row_mem [NUM_SETS];
  logic [ROW_W-1:0] rd_data_r;
  logic             mem_we, mem_re;
  logic [SW-1:0]    mem_waddr, mem_raddr;
  logic [ROW_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= row_mem[mem_raddr];
    end
  end

  // Control and state registers
  back_state_t        state_r, state_nxt;
  logic [SW-1:0]      clr_cnt_r;
  logic [SW:0]        walk_cnt_r;
  logic               wr_valid_r;
  logic [SW-1:0]      wr_addr_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] upd_cnt_r, upd_cnt_nxt;
  logic [SELECTOR_BITS-1:0] sel_r, sel_nxt;
  logic [SEED_W-1:0]  lfsr_r, lfsr_nxt;
  logic               out_valid_r;
  logic               out_kind_r;
  logic [WAY_W-1:0]   out_way_r;
  logic [SELV_W-1:0]  out_sel_r;

  // Item decode
  logic [31:0]        set_ext, way_ext;
  logic [SW-1:0]      item_addr;
  logic [PERIOD_W-1:0] period_eff, cnt_inc;
  logic               decay_due;
  logic               out_free, exec_fire;
  logic               walk_issue, walk_done;

  assign set_ext    = 32'(head_item.set_index);
  assign way_ext    = 32'(head_item.way_index);
  assign item_addr  = set_ext[SW-1:0];
  assign period_eff = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign cnt_inc    = upd_cnt_r + 1'b1;
  assign decay_due  = cnt_inc >= period_eff;
  assign out_free   = !out_valid_r || out_ready;
  assign walk_issue = walk_cnt_r != WALK_END;
  assign walk_done  = !walk_issue && !wr_valid_r;
  assign exec_fire  = (state_r == BK_EXEC) && out_free;

  // Victim selection: first invalid way, else age set and take first distant
  logic             inv_found;
  logic [WW-1:0]    inv_way;
  logic [1:0]       top, age;
  logic [ROW_W-1:0] aged_row;
  logic [WW-1:0]    far_way;
  logic             far_found;

  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < VIS_W; w++) begin
      if (!inv_found && !head_item.valid_mask[w]) begin
        inv_found = 1'b1;
        inv_way   = WW'(w);
      end
    end
    top = 2'd0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rd_data_r[w*LINE_W +: 2] > top) begin
        top = rd_data_r[w*LINE_W +: 2];
      end
    end
    age      = RRPV_DISTANT - top;
    aged_row = rd_data_r;
    far_found = 1'b0;
    far_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[w*LINE_W +: 2] = rd_data_r[w*LINE_W +: 2] + age;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!far_found && aged_row[w*LINE_W +: 2] == RRPV_DISTANT) begin
        far_found = 1'b1;
        far_way   = WW'(w);
      end
    end
  end

  // Update of one line
  logic [1:0]        old_dead, new_rrpv, new_dead;
  logic              use_static, bimodal;
  logic [SEED_W-1:0] lfsr_step;
  logic [ROW_W-1:0]  upd_row;
  logic              upd_live, sel_up;

  always_comb begin
    old_dead = 2'd0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_ext == 32'(w)) begin
        old_dead = rd_data_r[w*LINE_W+2 +: 2];
      end
    end
    use_static = head_item.leader ? head_item.srrip_leader : (sel_r >= SEL_MID);
    lfsr_step  = {1'b0, lfsr_r[SEED_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
    bimodal    = !head_item.was_hit && (old_dead != DEAD_MAX) && !use_static;
    if (head_item.was_hit) begin
      new_rrpv = RRPV_NEAR;
      new_dead = (old_dead != 2'd0) ? old_dead - 2'd1 : old_dead;
    end else begin
      if (old_dead == DEAD_MAX) begin
        new_rrpv = RRPV_DISTANT;
      end else if (use_static) begin
        new_rrpv = RRPV_LONG;
      end else begin
        new_rrpv = (lfsr_step[BIMODAL_BITS-1:0] == '0) ? RRPV_LONG : RRPV_DISTANT;
      end
      new_dead = (old_dead != DEAD_MAX) ? old_dead + 2'd1 : old_dead;
    end
    upd_row = rd_data_r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_ext == 32'(w)) begin
        upd_row[w*LINE_W +: 2]   = new_rrpv;
        upd_row[w*LINE_W+2 +: 2] = new_dead;
      end
    end
    upd_live = (head_item.op == OP_UPDATE) && head_item.set_ok && head_item.way_ok;
    sel_up   = head_item.srrip_leader ? head_item.was_hit : !head_item.was_hit;
    sel_nxt  = sel_r;
    if (upd_live && head_item.leader) begin
      if (sel_up) begin
        if (sel_r != SEL_MAX) begin
          sel_nxt = sel_r + 1'b1;
        end
      end else if (sel_r != '0) begin
        sel_nxt = sel_r - 1'b1;
      end
    end
    lfsr_nxt = (upd_live && bimodal) ? lfsr_step : lfsr_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          state_nxt = (head_item.op == OP_UPDATE && decay_due) ? BK_DECAY : BK_EXEC;
        end
      end
      BK_DECAY: begin
        if (walk_done) begin
          state_nxt = BK_FETCH;
        end
      end
      BK_FETCH: state_nxt = BK_EXEC;
      BK_EXEC: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  logic [WW-1:0] vic_way;
  logic [31:0]   vic_ext, sel_ext;

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = item_addr;
    mem_wdata   = upd_row;
    mem_re      = 1'b0;
    mem_raddr   = item_addr;
    pop         = 1'b0;
    upd_cnt_nxt = upd_cnt_r;
    vic_way     = inv_found ? inv_way : far_way;
    case (state_r)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = init_row();
      end
      BK_IDLE: begin
        if (head_valid) begin
          mem_re = 1'b1;
          if (head_item.op == OP_UPDATE) begin
            upd_cnt_nxt = decay_due ? '0 : cnt_inc;
          end
        end
      end
      BK_DECAY: begin
        mem_re    = walk_issue;
        mem_raddr = walk_cnt_r[SW-1:0];
        mem_we    = wr_valid_r;
        mem_waddr = wr_addr_r;
        mem_wdata = decay_row(rd_data_r);
      end
      BK_FETCH: begin
        mem_re = 1'b1;
      end
      BK_EXEC: begin
        if (out_free) begin
          pop = 1'b1;
          if (head_item.op == OP_UPDATE) begin
            mem_we = upd_live;
          end else begin
            mem_we    = head_item.set_ok && !inv_found;
            mem_wdata = aged_row;
          end
        end
      end
      default: ;
    endcase
    if (head_item.op == OP_VICTIM && head_item.set_ok) begin
      vic_ext = 32'(vic_way);
    end else begin
      vic_ext = '0;
    end
    sel_ext = 32'(sel_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      walk_cnt_r  <= '0;
      wr_valid_r  <= 1'b0;
      period_r    <= PERIOD_RESET;
      upd_cnt_r   <= '0;
      sel_r       <= SEL_MID;
      lfsr_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      upd_cnt_r <= upd_cnt_nxt;
      if (state_r == BK_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == BK_DECAY) begin
        wr_valid_r <= walk_issue;
        if (walk_issue) begin
          walk_cnt_r <= walk_cnt_r + 1'b1;
        end
      end else begin
        wr_valid_r <= 1'b0;
        walk_cnt_r <= '0;
      end
      if (exec_fire) begin
        sel_r <= sel_nxt;
      end
      if (cfg_we && cfg_index == CFG_RANDOM_SEED) begin
        // zero seed would lock the LFSR
        lfsr_r <= (cfg_data[SEED_W-1:0] == '0) ? SEED_W'(1) : cfg_data[SEED_W-1:0];
      end else if (exec_fire) begin
        lfsr_r <= lfsr_nxt;
      end
      if (cfg_we && cfg_index == CFG_DECAY_PERIOD) begin
        period_r <= cfg_data[PERIOD_W-1:0];
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_DECAY) begin
      wr_addr_r <= walk_cnt_r[SW-1:0];
    end
    if (exec_fire) begin
      out_kind_r <= head_item.op;
      out_way_r  <= vic_ext[WAY_W-1:0];
      out_sel_r  <= sel_ext[SELV_W-1:0];
    end
  end

  assign clear_busy         = state_r == BK_CLEAR;
  assign out_valid          = out_valid_r;
  assign out_reply_kind     = out_kind_r;
  assign out_victim_way     = out_way_r;
  assign out_selector_value = out_sel_r;

endmodule

// ===== src/drrip_dead_block_replacement.sv =====
`timescale 1ns / 1ps
// Flow: a request is queued, its set row is read, and the result is registered when
//   the result side is free. The back does one read-modify-write of a set row per
//   request through the single row memory (registered read, then write).
// Every decay_period updates, a walk over all NUM_SETS rows decays the dead counters.
// Reset: synchronous, active low; a clearing pass over all NUM_SETS rows follows, with
//   in_ready low, configuration writes still taken.
// ----------------------------------------------------------------------------
// drrip_dead_block_replacement
// DRRIP replacement engine with set dueling and per-line dead-block counters.
// ----------------------------------------------------------------------------
module drrip_dead_block_replacement #(
  parameter int NUM_SETS      = drrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS      = drrip_pkg::DEF_NUM_WAYS,
  parameter int LEADER_SETS   = drrip_pkg::DEF_LEADER_SETS,
  parameter int SELECTOR_BITS = drrip_pkg::DEF_SELECTOR_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [drrip_pkg::SET_W-1:0]      in_set_index,
  input  logic [drrip_pkg::WAY_W-1:0]      in_way_index,
  input  logic                             in_was_hit,
  input  logic [drrip_pkg::MASK_W-1:0]     in_valid_mask,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_reply_kind,
  output logic [drrip_pkg::WAY_W-1:0]      out_victim_way,
  output logic [drrip_pkg::SELV_W-1:0]     out_selector_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drrip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drrip_pkg::CFG_DATA_W-1:0] cfg_data
);
  import drrip_pkg::*;

  logic  q_full, push, pop, head_valid, clear_busy;
  item_t push_item, head_item;

  assign cfg_ready = 1'b1;

  drrip_front #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .LEADER_SETS (LEADER_SETS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_set_index  (in_set_index),
    .in_way_index  (in_way_index),
    .in_was_hit    (in_was_hit),
    .in_valid_mask (in_valid_mask),
    .q_full        (q_full),
    .clear_busy    (clear_busy),
    .push          (push),
    .push_item     (push_item)
  );

  drrip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  drrip_back #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .SELECTOR_BITS (SELECTOR_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .head_valid         (head_valid),
    .head_item          (head_item),
    .pop                (pop),
    .clear_busy         (clear_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reply_kind     (out_reply_kind),
    .out_victim_way     (out_victim_way),
    .out_selector_value (out_selector_value)
  );

endmodule

// ===== test/drrip_dead_block_replacement_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_dead_block_replacement_tb
// Self-checking bench for the DRRIP dead-block replacement engine. A short
// table of directed requests runs first, then random phases steer the policy
// selector to both limits under several decay periods and seeds. Every result
// is checked per field against typed table rows or a behavioral bench model.
// ----------------------------------------------------------------------------
module drrip_dead_block_replacement_tb;
  import drrip_pkg::*;

  localparam int NSETS       = DEF_NUM_SETS;
  localparam int NWAYS       = DEF_NUM_WAYS;
  localparam int NLEAD       = DEF_LEADER_SETS;
  localparam int LINES       = NSETS * NWAYS;
  localparam int SEL_TOP     = (1 << DEF_SELECTOR_BITS) - 1;
  localparam int SEL_HALF    = SEL_TOP / 2;
  localparam int CYCLE_LIMIT = 2_500_000;

  typedef struct packed {
    logic              op;
    logic [SET_W-1:0]  set_idx;
    logic [WAY_W-1:0]  way_idx;
    logic              hit;
    logic [MASK_W-1:0] mask;
  } req_s;

  typedef struct packed {
    logic              kind;
    logic [WAY_W-1:0]  victim;
    logic [SELV_W-1:0] sel;
  } reply_s;

  typedef struct packed {
    req_s   req;
    logic   typed;
    reply_s want;
  } dir_row_s;

  typedef enum logic [1:0] {STEER_MIX, STEER_UP, STEER_DOWN} steer_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [SET_W-1:0]      in_set_index;
  logic [WAY_W-1:0]      in_way_index;
  logic                  in_was_hit;
  logic [MASK_W-1:0]     in_valid_mask;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_reply_kind;
  logic [WAY_W-1:0]      out_victim_way;
  logic [SELV_W-1:0]     out_selector_value;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model of the replacement state
  logic [1:0]          rrpv_m [LINES];
  logic [1:0]          dead_m [LINES];
  logic [SELV_W-1:0]   psel_m;
  logic [PERIOD_W-1:0] upd_cnt_m;
  logic [PERIOD_W-1:0] period_m;
  logic [SEED_W-1:0]   lfsr_m;

  reply_s     pending_q [$];
  dir_row_s   dir_tab [$];
  logic [SET_W-1:0] set_pool [6];  // 0-1 static leaders, 2-3 bimodal leaders, 4-5 followers
  int         errors;
  int         quiet_in;
  int         quiet_out;

  drrip_dead_block_replacement i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_set_index       (in_set_index),
    .in_way_index       (in_way_index),
    .in_was_hit         (in_was_hit),
    .in_valid_mask      (in_valid_mask),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reply_kind     (out_reply_kind),
    .out_victim_way     (out_victim_way),
    .out_selector_value (out_selector_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic predict_reply(input req_s r, output reply_s y);
    int                  base;
    int                  idx;
    int                  w;
    logic [1:0]          top;
    logic [1:0]          age;
    logic [WAY_W-1:0]    pick;
    logic [PERIOD_W-1:0] per;
    bit                  found;
    bit                  leader;
    bit                  static_lead;
    bit                  up;
    pick  = '0;
    found = 1'b0;
    base  = int'(r.set_idx) * NWAYS;
    if (r.op == OP_VICTIM) begin
      for (w = 0; w < NWAYS; w++)
        if (!found && !r.mask[w]) begin
          pick  = WAY_W'(w);
          found = 1'b1;
        end
      if (!found) begin
        // age the whole set until some way reaches distant
        top = '0;
        for (w = 0; w < NWAYS; w++)
          if (rrpv_m[base + w] > top) top = rrpv_m[base + w];
        age = RRPV_DISTANT - top;
        for (w = 0; w < NWAYS; w++) rrpv_m[base + w] = rrpv_m[base + w] + age;
        for (w = 0; w < NWAYS; w++)
          if (!found && rrpv_m[base + w] == RRPV_DISTANT) begin
            pick  = WAY_W'(w);
            found = 1'b1;
          end
      end
    end else begin
      per = (period_m == '0) ? PERIOD_W'(1) : period_m;
      upd_cnt_m = upd_cnt_m + 1'b1;
      if (upd_cnt_m >= per) begin
        upd_cnt_m = '0;
        for (w = 0; w < LINES; w++)
          if (dead_m[w] != 2'd0) dead_m[w] = dead_m[w] - 1'b1;
      end
      idx         = base + int'(r.way_idx);
      leader      = r.set_idx < 2 * NLEAD;
      static_lead = r.set_idx < NLEAD;
      if (r.hit) begin
        rrpv_m[idx] = RRPV_NEAR;
        if (dead_m[idx] != 2'd0) dead_m[idx] = dead_m[idx] - 1'b1;
      end else begin
        if (dead_m[idx] == DEAD_MAX) begin
          rrpv_m[idx] = RRPV_DISTANT;
        end else if (leader ? static_lead : (psel_m >= SEL_HALF)) begin
          rrpv_m[idx] = RRPV_LONG;
        end else begin
          lfsr_m = (lfsr_m >> 1) ^ (lfsr_m[0] ? LFSR_TAPS : '0);
          rrpv_m[idx] = (lfsr_m[BIMODAL_BITS-1:0] == '0) ? RRPV_LONG : RRPV_DISTANT;
        end
        if (dead_m[idx] != DEAD_MAX) dead_m[idx] = dead_m[idx] + 1'b1;
      end
      if (leader) begin
        up = static_lead ? r.hit : !r.hit;
        if (up && psel_m < SEL_TOP) psel_m = psel_m + 1'b1;
        else if (!up && psel_m > 0) psel_m = psel_m - 1'b1;
      end
    end
    y.kind   = r.op;
    y.victim = pick;
    y.sel    = psel_m;
  endtask

  task automatic draw_gap(inout int quiet, output int gap);
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) quiet = $urandom_range(8, 40);
      gap = $urandom_range(0, 10);
    end
  endtask

  task automatic send_request(input req_s r, input logic typed, input reply_s want,
                              output reply_s y);
    int gap;
    draw_gap(quiet_in, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= r.op;
    in_set_index  <= r.set_idx;
    in_way_index  <= r.way_idx;
    in_was_hit    <= r.hit;
    in_valid_mask <= r.mask;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_reply(r, y);
    pending_q.push_back(typed ? want : y);
  endtask

  // valid is dropped in the step of the last accept, then all replies drain
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [PERIOD_W-1:0] per,
                              input logic [CFG_DATA_W-1:0] seed_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DECAY_PERIOD;
    cfg_data  <= per;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    period_m = per;
    cfg_index <= CFG_RANDOM_SEED;
    cfg_data  <= seed_word;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    // a zero seed loads one so the LFSR cannot lock up
    lfsr_m = (seed_word[SEED_W-1:0] == '0) ? SEED_W'(1) : seed_word[SEED_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic op, input int set_no, input int way_no, input logic hit,
                         input logic [MASK_W-1:0] mask, input logic typed,
                         input int victim, input int sel);
    dir_row_s row;
    row.req.op      = op;
    row.req.set_idx = SET_W'(set_no);
    row.req.way_idx = WAY_W'(way_no);
    row.req.hit     = hit;
    row.req.mask    = mask;
    row.typed       = typed;
    row.want.kind   = op;
    row.want.victim = WAY_W'(victim);
    row.want.sel    = SELV_W'(sel);
    dir_tab.push_back(row);
  endtask

  function automatic req_s any_request();
    req_s r;
    r.op      = $urandom_range(0, 1);
    r.set_idx = SET_W'($urandom);
    r.way_idx = WAY_W'($urandom);
    r.hit     = $urandom_range(0, 1);
    r.mask    = MASK_W'($urandom);
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] any_mask();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return '1;
    if (roll < 8) return ~(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
    return MASK_W'($urandom);
  endfunction

  // a few ways per set so lines see repeated misses and dead counters saturate
  function automatic logic [WAY_W-1:0] any_way();
    if ($urandom_range(0, 3) != 0) return WAY_W'($urandom_range(0, 3));
    return WAY_W'($urandom_range(0, NWAYS - 1));
  endfunction

  task automatic run_phase(input logic [PERIOD_W-1:0] per,
                           input logic [CFG_DATA_W-1:0] seed_word,
                           input steer_e steer, input int count);
    int     sent;
    int     roll;
    int     w;
    req_s   r;
    reply_s y;
    write_config(per, seed_word);
    set_pool[0] = $urandom_range(0, NLEAD - 1);
    set_pool[1] = $urandom_range(0, NLEAD - 1);
    set_pool[2] = $urandom_range(NLEAD, 2 * NLEAD - 1);
    set_pool[3] = $urandom_range(NLEAD, 2 * NLEAD - 1);
    set_pool[4] = $urandom_range(2 * NLEAD, NSETS - 1);
    set_pool[5] = $urandom_range(2 * NLEAD, NSETS - 1);
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      r    = any_request();
      if (steer != STEER_MIX && roll >= 4) begin
        // leader update that moves the selector toward the steered limit
        r.op      = OP_UPDATE;
        r.way_idx = any_way();
        if ($urandom_range(0, 1)) begin
          r.set_idx = set_pool[$urandom_range(0, 1)];
          r.hit     = (steer == STEER_UP);
        end else begin
          r.set_idx = set_pool[$urandom_range(2, 3)];
          r.hit     = (steer == STEER_DOWN);
        end
        send_request(r, 1'b0, '0, y);
        sent++;
      end else if (roll < 40) begin
        // victim request, then the miss fill of the chosen way
        r.op      = OP_VICTIM;
        r.set_idx = set_pool[$urandom_range(0, 5)];
        r.mask    = any_mask();
        send_request(r, 1'b0, '0, y);
        r.op      = OP_UPDATE;
        r.way_idx = y.victim;
        r.hit     = 1'b0;
        send_request(r, 1'b0, '0, y);
        sent += 2;
      end else if (roll < 44) begin
        // touch every way of a set so the next victim request ages from near
        r.set_idx = set_pool[$urandom_range(0, 5)];
        r.op      = OP_UPDATE;
        r.hit     = 1'b1;
        for (w = 0; w < NWAYS; w++) begin
          r.way_idx = WAY_W'(w);
          send_request(r, 1'b0, '0, y);
        end
        r.op   = OP_VICTIM;
        r.mask = '1;
        send_request(r, 1'b0, '0, y);
        sent += NWAYS + 1;
      end else if (roll < 92) begin
        r.op      = OP_UPDATE;
        r.set_idx = set_pool[$urandom_range(0, 5)];
        r.way_idx = any_way();
        send_request(r, 1'b0, '0, y);
        sent++;
      end else begin
        send_request(r, 1'b0, '0, y);
        sent++;
      end
    end
    drain_requests();
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin : result_check
    reply_s got;
    reply_s want;
    int     gap;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      draw_gap(quiet_out, gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.kind   = out_reply_kind;
      got.victim = out_victim_way;
      got.sel    = out_selector_value;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected reply kind %0d way %0d selector %0d",
                 $time, got.kind, got.victim, got.sel);
        errors++;
      end else begin
        want = pending_q.pop_front();
        report_field("reply_kind", want.kind, got.kind);
        report_field("victim_way", want.victim, got.victim);
        report_field("selector_value", want.sel, got.sel);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("drrip_dead_block_replacement_tb: errors");
    $finish;
  end

  initial begin : stimulus
    reply_s y;
    int     i;
    errors    = 0;
    quiet_in  = 0;
    quiet_out = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_VICTIM;
    in_set_index  <= '0;
    in_way_index  <= '0;
    in_was_hit    <= 1'b0;
    in_valid_mask <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_DECAY_PERIOD;
    cfg_data      <= '0;
    for (i = 0; i < LINES; i++) begin
      rrpv_m[i] = RRPV_DISTANT;
      dead_m[i] = 2'd0;
    end
    psel_m    = SELV_W'(SEL_HALF);
    upd_cnt_m = '0;
    period_m  = PERIOD_RESET;
    lfsr_m    = SEED_RESET;

    //       op         set   way hit mask      typed way sel
    add_row(OP_VICTIM,    0,   0, 0, 16'hFFFF, 1,    0, 511);  // all lines distant
    add_row(OP_VICTIM, 2047,  15, 1, 16'h0000, 1,    0, 511);
    add_row(OP_VICTIM, 1000,   0, 0, 16'h7FFF, 1,   15, 511);  // only the top way invalid
    add_row(OP_UPDATE,    0,   0, 1, 16'hFFFF, 1,    0, 512);  // static leader hit
    add_row(OP_UPDATE,   64,  15, 1, 16'h0000, 1,    0, 511);  // bimodal leader hit
    add_row(OP_UPDATE,    0,   0, 0, 16'hFFFF, 1,    0, 510);
    add_row(OP_UPDATE,   63,   1, 0, 16'h0000, 1,    0, 509);
    add_row(OP_UPDATE,  127,   2, 1, 16'hFFFF, 1,    0, 508);
    add_row(OP_UPDATE,   64,   3, 0, 16'hFFFF, 1,    0, 509);
    add_row(OP_UPDATE,  128,   4, 0, 16'h0000, 1,    0, 509);  // follower, bimodal
    add_row(OP_UPDATE, 2047,  15, 0, 16'hFFFF, 1,    0, 509);
    add_row(OP_VICTIM,    0,   0, 0, 16'hFFFF, 0,    0,   0);
    add_row(OP_UPDATE,    0,   1, 0, 16'hFFFF, 0,    0,   0);
    add_row(OP_VICTIM,   64,   0, 0, 16'hFFFF, 0,    0,   0);
    add_row(OP_UPDATE, 2047,  15, 1, 16'h0000, 0,    0,   0);
    add_row(OP_VICTIM, 2047,   0, 0, 16'h8000, 0,    0,   0);
    add_row(OP_UPDATE,    0,   0, 0, 16'hFFFF, 0,    0,   0);
    add_row(OP_UPDATE,    0,   0, 0, 16'hFFFF, 0,    0,   0);  // dead counter saturates
    add_row(OP_UPDATE,    0,   0, 0, 16'hFFFF, 0,    0,   0);  // dead line goes distant
    add_row(OP_VICTIM,    0,   0, 0, 16'hFFFF, 0,    0,   0);
    add_row(OP_UPDATE,  500,   7, 1, 16'hFFFF, 0,    0,   0);
    add_row(OP_VICTIM, 1365,   0, 0, 16'h5555, 0,    0,   0);
    add_row(OP_VICTIM,  682,  15, 1, 16'hAAAA, 0,    0,   0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_tab.size(); i++)
      send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want, y);
    drain_requests();

    run_phase(20'd8, 20'h00000, STEER_DOWN, 580);
    run_phase(20'd0, 20'h0FFFF, STEER_MIX, 40);
    run_phase(20'd1, 20'h00001, STEER_MIX, 30);
    run_phase(20'hFFFFF, 20'hF5A3C, STEER_UP, 1120);
    run_phase(PERIOD_W'($urandom_range(4, 64)), CFG_DATA_W'($urandom), STEER_MIX, 300);

    if (errors == 0) begin
      $display("drrip_dead_block_replacement_tb: clean");
    end else begin
      $display("drrip_dead_block_replacement_tb: errors");
    end
    $finish;
  end

endmodule
